// ===== hdl/cspi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cspi_pkg
// Types, widths and constants shared by the position interpolator modules.
// ----------------------------------------------------------------------------
package cspi_pkg;

    localparam int DELTA_W   = 32;
    localparam int SUM_W     = 64;
    localparam int RATIO_W   = 8;
    localparam int STEP_W    = 24;
    localparam int LIM_W     = STEP_W + 1;
    localparam int INC_W     = DELTA_W + 2;
    localparam int REM_W     = RATIO_W;
    localparam int CFG_DATA_W = STEP_W;
    localparam int REG_IDX_W = 1;

    // serial divider: one quotient bit per cycle over the whole numerator
    localparam int DIV_STEPS = SUM_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // step limit = max_step + max_step / 50, the division done by reciprocal
    localparam int LIMIT_DIVISOR = 50;
    localparam int RECIP_SHIFT   = 32;
    localparam int RECIP_W       = 27;
    localparam int PROD_W        = STEP_W + RECIP_W;
    localparam logic [RECIP_W-1:0] LIMIT_RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + LIMIT_DIVISOR - 1) / LIMIT_DIVISOR);

    localparam logic [RATIO_W-1:0] SYNC_RATIO_RESET = RATIO_W'(4);

    typedef enum logic [REG_IDX_W-1:0] {
        REG_SYNC_RATIO = 1'b0,
        REG_MAX_STEP   = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic                      drive_active;
        logic                      run_armed;
        logic signed [DELTA_W-1:0] period_delta;
    } in_item_t;

    typedef struct packed {
        logic signed [DELTA_W-1:0] tick_increment;
        logic                      following;
        logic signed [SUM_W-1:0]   remaining_sum;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_ABS,
        ST_DIV,
        ST_FIX,
        ST_COMP,
        ST_CLAMP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic clear;
        logic tick_dec;
        logic inc_held;
        logic inc_zero;
        logic reload;
        logic abs;
        logic div_step;
        logic fix;
        logic comp;
        logic clamp;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic active;
        logic armed;
        logic tick_gt1;
        logic ratio_zero;
        logic out_busy;
    } dp_status_t;

endpackage

// ===== hdl/cspi_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cspi_in_if / cspi_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface cspi_in_if
    import cspi_pkg::*;
();
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cspi_out_if
    import cspi_pkg::*;
();
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/cspi_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cspi_ctrl
// Sequencer: picks the path for each item and steps the serial divider.
// ----------------------------------------------------------------------------
module cspi_ctrl
    import cspi_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd,
    output logic       in_ready
);

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (status.in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                priority if (!status.active)
                begin
                    cmd.clear  = 1'b1;
                    state_next = ST_EMIT;
                end
                else if (!status.armed)
                begin
                    cmd.inc_zero = 1'b1;
                    state_next   = ST_COMP;
                end
                else if (status.tick_gt1)
                begin
                    cmd.tick_dec = 1'b1;
                    cmd.inc_held = 1'b1;
                    state_next   = ST_COMP;
                end
                else
                begin
                    cmd.reload = 1'b1;
                    if (status.ratio_zero)
                    begin
                        cmd.inc_zero = 1'b1;
                        state_next   = ST_COMP;
                    end
                    else
                    begin
                        state_next = ST_ABS;
                    end
                end
            end
            ST_ABS:
            begin
                cmd.abs    = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX:
            begin
                cmd.fix    = 1'b1;
                state_next = ST_COMP;
            end
            ST_COMP:
            begin
                cmd.comp   = 1'b1;
                state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                cmd.clamp  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // wait until the output register can take the result
                if (!status.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && cnt_reg != CNT_LAST) |=> state_reg == ST_DIV)
        else $error("divider left before the last step");

    a_abs_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ABS |=> (state_reg == ST_DIV && cnt_reg == '0))
        else $error("divider not started at step zero");

    a_fix_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FIX |-> ($past(state_reg) == ST_DIV && $past(cnt_reg) == CNT_LAST))
        else $error("quotient taken before the division finished");
`endif

endmodule

// ===== hdl/cspi_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cspi_dp
// Datapath: configuration, interpolation state, serial divider, remainder
// feedback, step clamp and the result register.
// ----------------------------------------------------------------------------
module cspi_dp
    import cspi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctrl_cmd_t             cmd,
    output dp_status_t            status,
    input  logic                  in_valid,
    input  in_item_t              in_data,
    output logic                  out_valid,
    output out_item_t             out_data,
    input  logic                  out_ready,
    input  logic                  wr_en,
    input  logic [REG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data
);

    // configuration
    logic [RATIO_W-1:0] ratio_reg, ratio_next;
    logic [LIM_W-1:0]   lim_reg, lim_next;
    logic [PROD_W-1:0]  lim_prod;

    // interpolation state
    logic [RATIO_W-1:0] tick_reg, tick_next;
    logic [DELTA_W-1:0] held_reg, held_next;
    logic [SUM_W-1:0]   carry_reg, carry_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;

    // working registers
    in_item_t                item_reg, item_next;
    logic [SUM_W-1:0]        num_reg, num_next;
    logic [REM_W-1:0]        rem_reg, rem_next;
    logic                    neg_reg, neg_next;
    logic signed [INC_W-1:0] inc_reg, inc_next;
    out_item_t               out_reg, out_next;
    logic                    out_valid_reg, out_valid_next;

    logic [SUM_W-1:0]        delta_ext;
    logic [REM_W:0]          trial;
    logic [REM_W:0]          ratio_ext;
    logic                    trial_fits;
    logic [DELTA_W-1:0]      quo_lo;
    logic [SUM_W-1:0]        rem_ext;
    logic                    carry_nz;
    logic                    inc_nz;
    logic signed [INC_W-1:0] lim_s;
    logic signed [INC_W-1:0] inc_plus_lim;
    logic                    over;
    logic                    under;
    logic [INC_W-1:0]        excess;
    logic [SUM_W-1:0]        sum_after;

    assign lim_prod  = PROD_W'(wr_data) * PROD_W'(LIMIT_RECIP);
    assign delta_ext = {{(SUM_W-DELTA_W){item_reg.period_delta[DELTA_W-1]}},
                        item_reg.period_delta};

    // one restoring step: remainder stays below the divisor
    assign ratio_ext  = {1'b0, ratio_reg};
    assign trial      = {rem_reg, num_reg[SUM_W-1]};
    assign trial_fits = (trial >= ratio_ext);

    assign quo_lo  = neg_reg ? (DELTA_W'(0) - num_reg[DELTA_W-1:0]) : num_reg[DELTA_W-1:0];
    assign rem_ext = neg_reg ? (SUM_W'(0) - SUM_W'(rem_reg)) : SUM_W'(rem_reg);

    assign carry_nz = (carry_reg != '0);
    assign inc_nz   = (inc_reg != '0);

    assign lim_s        = $signed({{(INC_W-LIM_W){1'b0}}, lim_reg});
    assign inc_plus_lim = inc_reg + lim_s;
    assign over         = (inc_reg >= lim_s);
    assign under        = inc_plus_lim[INC_W-1] || (inc_plus_lim == '0);
    assign excess       = over ? INC_W'(inc_reg - lim_s) : INC_W'(inc_plus_lim);

    assign sum_after = sum_reg - {{(SUM_W-INC_W){inc_reg[INC_W-1]}}, inc_reg};

    always_comb
    begin
        ratio_next     = ratio_reg;
        lim_next       = lim_reg;
        tick_next      = tick_reg;
        held_next      = held_reg;
        carry_next     = carry_reg;
        sum_next       = sum_reg;
        item_next      = item_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        neg_next       = neg_reg;
        inc_next       = inc_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (wr_en)
        begin
            unique case (reg_index_t'(wr_index))
                REG_SYNC_RATIO: ratio_next = wr_data[RATIO_W-1:0];
                REG_MAX_STEP:   lim_next = LIM_W'(wr_data) + LIM_W'(lim_prod >> RECIP_SHIFT);
            endcase
        end

        if (cmd.capture)
        begin
            item_next = in_data;
        end

        if (cmd.clear)
        begin
            tick_next  = '0;
            carry_next = '0;
            sum_next   = '0;
            inc_next   = '0;
        end

        if (cmd.tick_dec)
        begin
            tick_next = tick_reg - RATIO_W'(1);
        end

        if (cmd.inc_held)
        begin
            inc_next = $signed({{(INC_W-DELTA_W){held_reg[DELTA_W-1]}}, held_reg});
        end

        if (cmd.reload)
        begin
            tick_next = ratio_reg;
            sum_next  = sum_reg + delta_ext;
            num_next  = delta_ext + carry_reg;
            if (ratio_reg == '0)
            begin
                held_next = '0;
            end
        end

        if (cmd.inc_zero)
        begin
            inc_next = '0;
        end

        if (cmd.abs)
        begin
            neg_next = num_reg[SUM_W-1];
            num_next = num_reg[SUM_W-1] ? (SUM_W'(0) - num_reg) : num_reg;
            rem_next = '0;
        end

        if (cmd.div_step)
        begin
            num_next = {num_reg[SUM_W-2:0], trial_fits};
            rem_next = trial_fits ? REM_W'(trial - ratio_ext) : REM_W'(trial);
        end

        if (cmd.fix)
        begin
            held_next  = quo_lo;
            carry_next = rem_ext;
            inc_next   = $signed({{(INC_W-DELTA_W){quo_lo[DELTA_W-1]}}, quo_lo});
        end

        // move one count of the carried remainder into the increment
        if (cmd.comp && carry_nz)
        begin
            if (!carry_reg[SUM_W-1] && !inc_reg[INC_W-1])
            begin
                inc_next   = inc_reg + INC_W'(1);
                carry_next = carry_reg - SUM_W'(1);
            end
            else if (carry_reg[SUM_W-1] && (inc_reg[INC_W-1] || !inc_nz))
            begin
                inc_next   = inc_reg - INC_W'(1);
                carry_next = carry_reg + SUM_W'(1);
            end
        end

        // clamp and push the excess back into the remainder
        if (cmd.clamp && (over || under))
        begin
            carry_next = carry_reg + {{(SUM_W-INC_W){excess[INC_W-1]}}, excess};
            inc_next   = over ? lim_s : (INC_W'(0) - lim_s);
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.emit)
        begin
            sum_next                = sum_after;
            out_next.tick_increment = inc_reg[DELTA_W-1:0];
            out_next.following      = item_reg.drive_active;
            out_next.remaining_sum  = sum_after;
            out_valid_next          = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg     <= SYNC_RATIO_RESET;
            lim_reg       <= '0;
            tick_reg      <= '0;
            held_reg      <= '0;
            carry_reg     <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ratio_reg     <= ratio_next;
            lim_reg       <= lim_next;
            tick_reg      <= tick_next;
            held_reg      <= held_next;
            carry_reg     <= carry_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        neg_reg  <= neg_next;
        inc_reg  <= inc_next;
        out_reg  <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign status.in_valid   = in_valid;
    assign status.active     = item_reg.drive_active;
    assign status.armed      = item_reg.run_armed;
    assign status.tick_gt1   = (tick_reg > RATIO_W'(1));
    assign status.ratio_zero = (ratio_reg == '0);
    assign status.out_busy   = out_valid_reg && !out_ready;

`ifndef ASSERT_OFF
    a_idle_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.following)
            |-> (out_reg.tick_increment == '0 && out_reg.remaining_sum == '0))
        else $error("inactive item gave a nonzero result");

    a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (rem_reg < ratio_reg))
        else $error("partial remainder not below the sync ratio");
`endif

endmodule

// ===== hdl/csp_position_interpolator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csp_position_interpolator
// Cyclic synchronous position interpolation: spreads each sync period's
// position delta over the position-loop ticks with remainder feedback.
// ----------------------------------------------------------------------------
// usage
//   sample: one item per position-loop tick (drive_active, run_armed,
//     period_delta). result: one item per input item (tick_increment,
//     following, remaining_sum). config: wr_en / wr_index / wr_data, index 0
//     sync_ratio, index 1 max_step; write only while no item is in flight.
//   one item at a time. sample.ready is high only while the sequencer idles.
//   path from accept to result valid:
//     drive inactive: decide, then emit
//     ticks between reloads, not armed, or sync_ratio zero: decide, feedback, clamp, emit
//     reload with sync_ratio nonzero: decide, sign, the 64-step serial divider
//     (one quotient bit per cycle), quotient fix, feedback, clamp, emit
//   the next item can be taken in the cycle after its predecessor's result is
//   loaded, even if that result still waits in the output register.
//   a stalled receiver holds the result; a finished item waits for the
//   register to drain. reset clears the interpolation state and result
//   valid, sync_ratio returns to 4 and max_step to 0; no clearing pass is needed.
// ----------------------------------------------------------------------------
module csp_position_interpolator
    import cspi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    cspi_in_if.sink               sample,
    cspi_out_if.source            result,
    input  logic                  wr_en,
    input  logic [REG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic       in_ready;

    cspi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .status   (status),
        .cmd      (cmd),
        .in_ready (in_ready)
    );

    cspi_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_valid  (sample.valid),
        .in_data   (sample.data),
        .out_valid (result.valid),
        .out_data  (result.data),
        .out_ready (result.ready),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data)
    );

    assign sample.ready = in_ready;

endmodule

// ===== verif/cspi_tick_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cspi_tick_checker
// Watches the sample, result and register-write ports of the position
// interpolator, predicts each tick's increment and remaining sum, and counts
// every result that differs from the prediction or arrives unasked.
// ----------------------------------------------------------------------------
module cspi_tick_checker
    import cspi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    cspi_in_if                    sample,
    cspi_out_if                   result,
    input  logic                  wr_en,
    input  logic [REG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output int                    errors,
    output int                    pending
);

    logic [RATIO_W-1:0]        ratio_cfg;
    logic [STEP_W-1:0]         step_cfg;
    logic [RATIO_W-1:0]        ticks_left;
    logic signed [DELTA_W-1:0] avg_hold;
    logic [SUM_W-1:0]          rem_carry;
    logic [SUM_W-1:0]          sum_open;
    out_item_t                 ticks_due[$];
    int                        mismatches;

    function automatic out_item_t interpolate_tick(input in_item_t it);
        out_item_t        r;
        logic [SUM_W-1:0] num;
        logic [SUM_W-1:0] mag;
        logic [SUM_W-1:0] quo;
        logic [SUM_W-1:0] rest;
        logic [SUM_W-1:0] delta_ext;
        logic             neg;
        longint           inc;
        longint           lim;
        r = '0;
        // inactive drive wipes the interpolation but keeps the held average
        if (!it.drive_active) begin
            ticks_left = '0;
            rem_carry  = '0;
            sum_open   = '0;
            return r;
        end
        if (it.run_armed) begin
            if (ticks_left > 1) begin
                ticks_left = ticks_left - 1'b1;
            end
            else begin
                ticks_left = ratio_cfg;
                delta_ext  = SUM_W'(longint'($signed(it.period_delta)));
                sum_open   = sum_open + delta_ext;
                if (ratio_cfg != '0) begin
                    // truncating division on the magnitude, sign put back after
                    num       = delta_ext + rem_carry;
                    neg       = num[SUM_W-1];
                    mag       = neg ? -num : num;
                    quo       = mag / ratio_cfg;
                    rest      = mag % ratio_cfg;
                    quo       = neg ? -quo : quo;
                    avg_hold  = quo[DELTA_W-1:0];
                    rem_carry = neg ? -rest : rest;
                end
                else begin
                    avg_hold = '0;
                end
            end
            inc = longint'(avg_hold);
        end
        else begin
            inc = 0;
        end
        // one count of remainder feedback per tick
        if (rem_carry != '0) begin
            if (!rem_carry[SUM_W-1]) begin
                if (inc >= 0) begin
                    inc       = inc + 1;
                    rem_carry = rem_carry - 1'b1;
                end
            end
            else if (inc <= 0) begin
                inc       = inc - 1;
                rem_carry = rem_carry + 1'b1;
            end
        end
        lim = longint'(step_cfg) + longint'(step_cfg / LIMIT_DIVISOR);
        if (inc >= lim) begin
            rem_carry = rem_carry + SUM_W'(inc - lim);
            inc       = lim;
        end
        else if (inc + lim <= 0) begin
            rem_carry = rem_carry + SUM_W'(inc + lim);
            inc       = -lim;
        end
        sum_open           = sum_open - SUM_W'(inc);
        r.tick_increment   = inc[DELTA_W-1:0];
        r.following        = 1'b1;
        r.remaining_sum    = sum_open;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        out_item_t got;
        if (!rst_n) begin
            ratio_cfg  = SYNC_RATIO_RESET;
            step_cfg   = '0;
            ticks_left = '0;
            avg_hold   = '0;
            rem_carry  = '0;
            sum_open   = '0;
            ticks_due.delete();
            mismatches = 0;
            errors     <= 0;
            pending    <= 0;
        end
        else begin
            if (wr_en) begin
                if (reg_index_t'(wr_index) == REG_SYNC_RATIO) begin
                    ratio_cfg = wr_data[RATIO_W-1:0];
                end
                else if (reg_index_t'(wr_index) == REG_MAX_STEP) begin
                    step_cfg = wr_data[STEP_W-1:0];
                end
            end
            if (result.valid && result.ready) begin
                got = result.data;
                if (ticks_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: unexpected item: inc %0d follow %0b sum %0d", $realtime,
                                 got.tick_increment, got.following, got.remaining_sum);
                    end
                end
                else begin
                    want = ticks_due.pop_front();
                    if (got.tick_increment !== want.tick_increment ||
                        got.following !== want.following ||
                        got.remaining_sum !== want.remaining_sum) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: mismatch: expected inc %0d follow %0b sum %0d",
                                     $realtime, want.tick_increment, want.following,
                                     want.remaining_sum);
                            $display("%0t:           actual   inc %0d follow %0b sum %0d",
                                     $realtime, got.tick_increment, got.following,
                                     got.remaining_sum);
                        end
                    end
                end
            end
            if (sample.valid && sample.ready) begin
                ticks_due.push_back(interpolate_tick(sample.data));
            end
            errors  <= mismatches;
            pending <= ticks_due.size();
        end
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the position interpolator with directed and random ticks across
// several register settings, with bursty input and a stalling receiver, and
// reports the verdict from the checker's counts.
// ----------------------------------------------------------------------------
module tb_top
    import cspi_pkg::*;
();

    localparam int CLK_HALF     = 5;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 1630;
    localparam int PHASE_ITEMS  = 160;
    localparam int DRAIN_CYCLES = 80;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SLOW,
        RX_MOSTLY
    } rx_mode_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  wr_en;
    logic [REG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;
    int                    errors;
    int                    pending;
    int                    cycle_count = 0;
    rx_mode_t              rx_mode = RX_OPEN;
    int                    rx_timer = 0;
    int                    burst_left = 1;
    bit                    sending = 1'b0;
    logic [RATIO_W-1:0]    cur_ratio = SYNC_RATIO_RESET;
    logic [STEP_W-1:0]     cur_step = '0;

    cspi_in_if  sample_ch ();
    cspi_out_if result_ch ();

    csp_position_interpolator i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .sample   (sample_ch),
        .result   (result_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    cspi_tick_checker i_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .sample   (sample_ch),
        .result   (result_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .errors   (errors),
        .pending  (pending)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[csp_position_interpolator] ERROR");
            $finish;
        end
    end

    // receiver stalls in stretches of different character
    always @(posedge clk)
    begin
        if (rx_timer == 0) begin
            rx_mode  <= rx_mode_t'($urandom_range(0, 3));
            rx_timer <= $urandom_range(50, 400);
        end
        else begin
            rx_timer <= rx_timer - 1;
        end
        case (rx_mode)
            RX_OPEN:   result_ch.ready <= 1'b1;
            RX_COIN:   result_ch.ready <= ($urandom_range(0, 1) == 1);
            RX_SLOW:   result_ch.ready <= ((cycle_count % 16) < 3);
            default:   result_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    function automatic in_item_t mk_tick(input logic act, input logic arm,
                                         input logic [DELTA_W-1:0] delta);
        in_item_t it;
        it.drive_active = act;
        it.run_armed    = arm;
        it.period_delta = delta;
        return it;
    endfunction

    // scale 0: full range, 1: around the clamp limit, 2: around the ratio
    function automatic logic [DELTA_W-1:0] rand_delta(input int scale);
        longint span;
        case (scale)
            0:       return $urandom;
            1:       span = (longint'(cur_step) + longint'(cur_step) / LIMIT_DIVISOR)
                            * (longint'(cur_ratio) + 1) * 2 + 64;
            default: span = longint'(cur_ratio) * 4 + 4;
        endcase
        if (span > (longint'(1) << 30)) begin
            span = longint'(1) << 30;
        end
        return DELTA_W'(longint'($urandom_range(0, 32'(2 * span))) - span);
    endfunction

    task automatic send_tick(input in_item_t it);
        sample_ch.valid <= 1'b1;
        sample_ch.data  <= it;
        sending = 1'b1;
        @(posedge clk);
        while (!sample_ch.ready) begin
            @(posedge clk);
        end
        burst_left--;
        if (burst_left <= 0) begin
            sample_ch.valid <= 1'b0;
            sending = 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 12);
        end
    endtask

    task automatic settle();
        if (sending) begin
            sample_ch.valid <= 1'b0;
            sending = 1'b0;
        end
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic configure(input logic [RATIO_W-1:0] ratio, input logic [STEP_W-1:0] step);
        wr_en    <= 1'b1;
        wr_index <= REG_SYNC_RATIO;
        wr_data  <= CFG_DATA_W'(ratio);
        @(posedge clk);
        wr_index <= REG_MAX_STEP;
        wr_data  <= CFG_DATA_W'(step);
        @(posedge clk);
        wr_en <= 1'b0;
        cur_ratio = ratio;
        cur_step  = step;
    endtask

    initial
    begin
        int                 issued;
        int                 phase_end;
        int                 run_len;
        int                 scale;
        logic [RATIO_W-1:0] ratio;
        logic [STEP_W-1:0]  step;
        issued = 0;
        sample_ch.valid <= 1'b0;
        sample_ch.data  <= '0;
        wr_en           <= 1'b0;
        wr_index        <= REG_SYNC_RATIO;
        wr_data         <= '0;
        rst_n           <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: step limit zero sends everything to the remainder
        send_tick(mk_tick(1'b1, 1'b1, 32'h7FFF_FFFF));
        send_tick(mk_tick(1'b1, 1'b1, 32'h0000_0000));
        send_tick(mk_tick(1'b1, 1'b0, 32'h1234_5678));
        send_tick(mk_tick(1'b1, 1'b1, 32'hFFFF_FFF0));
        send_tick(mk_tick(1'b0, 1'b1, 32'h0000_0005));

        // widest limit, one tick per period
        settle();
        configure(8'd1, 24'hFF_FFFF);
        send_tick(mk_tick(1'b1, 1'b1, 32'h8000_0000));
        send_tick(mk_tick(1'b1, 1'b1, 32'h7FFF_FFFF));
        send_tick(mk_tick(1'b1, 1'b1, 32'hFFFF_FFFF));
        send_tick(mk_tick(1'b1, 1'b1, 32'h0000_0001));
        send_tick(mk_tick(1'b1, 1'b0, 32'h0000_007B));
        send_tick(mk_tick(1'b0, 1'b0, 32'h0000_0000));

        // zero ratio reloads every tick
        settle();
        configure(8'd0, 24'hFF_FFFF);
        send_tick(mk_tick(1'b1, 1'b1, 32'd1000));
        send_tick(mk_tick(1'b1, 1'b1, -32'sd1000));
        send_tick(mk_tick(1'b1, 1'b0, 32'h0000_0000));
        send_tick(mk_tick(1'b1, 1'b1, 32'hFFFF_FFFF));

        // longest period with a tight limit
        settle();
        configure(8'd255, 24'd100);
        send_tick(mk_tick(1'b1, 1'b1, 32'h8000_0000));
        send_tick(mk_tick(1'b1, 1'b1, 32'h0000_0000));
        send_tick(mk_tick(1'b1, 1'b1, 32'h0000_0000));
        send_tick(mk_tick(1'b1, 1'b1, 32'h0000_0000));
        send_tick(mk_tick(1'b0, 1'b0, 32'hFFFF_FFFF));
        send_tick(mk_tick(1'b1, 1'b1, 32'd12345));

        for (int ph = 0; issued < RANDOM_ITEMS; ph++) begin
            case (ph)
                0:       begin ratio = 8'd255; step = 24'hFF_FFFF; end
                1:       begin ratio = 8'd1;   step = 24'd0;       end
                2:       begin ratio = 8'd0;   step = 24'd50;      end
                3:       begin ratio = 8'd2;   step = 24'd49;      end
                default:
                begin
                    case ($urandom_range(0, 4))
                        0:       ratio = 8'd1;
                        1:       ratio = 8'd0;
                        2:       ratio = 8'd255;
                        default: ratio = RATIO_W'($urandom_range(2, 16));
                    endcase
                    case ($urandom_range(0, 5))
                        0:       step = 24'd0;
                        1:       step = 24'hFF_FFFF;
                        2:       step = STEP_W'($urandom_range(1, 60));
                        3:       step = STEP_W'($urandom);
                        default: step = STEP_W'($urandom_range(1, 5000));
                    endcase
                end
            endcase
            settle();
            configure(ratio, step);
            phase_end = issued + PHASE_ITEMS;
            while (issued < phase_end) begin
                if ($urandom_range(0, 9) < 8) begin
                    // armed run across several reloads
                    run_len = $urandom_range(4, 80);
                    scale   = $urandom_range(0, 2);
                    repeat (run_len) begin
                        send_tick(mk_tick(1'b1, 1'b1, rand_delta(scale)));
                        issued++;
                    end
                end
                else begin
                    run_len = $urandom_range(1, 8);
                    repeat (run_len) begin
                        send_tick(mk_tick($urandom_range(0, 2) != 0, $urandom_range(0, 1) == 1,
                                          rand_delta($urandom_range(0, 1))));
                        issued++;
                    end
                end
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0) begin
            $display("[csp_position_interpolator] OK");
        end
        else begin
            $display("[csp_position_interpolator] ERROR");
        end
        $finish;
    end

endmodule
